/* rtl/spae_pkg.sv */
// Package for the steady peak amplitude estimator: sizes, beat types and the
// job record passed from the sample front end to the averaging back end.
// No dependencies.
package spae_pkg;

  localparam int MAX_PEAKS   = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int TIME_W      = 32;
  localparam int AMP_W       = 16;
  localparam int CFG_W       = 32;
  localparam int PTA_W       = 5;
  localparam int MAG_W       = SAMPLE_BITS + 1;
  localparam int PTR_W       = $clog2(MAX_PEAKS);
  localparam int CNT_W       = $clog2(MAX_PEAKS + 1);
  localparam int SUM_W       = MAG_W + PTR_W;
  localparam int STEP_W      = $clog2(SUM_W);
  localparam int SEEN_W      = 2;

  localparam logic [2:0] SEEN_FULL  = 3'd3;
  localparam logic [4:0] PTA_RESET  = 5'd10;

  // register indexes of the write port
  localparam logic REG_TRANSIENT_TIME   = 1'b0;
  localparam logic REG_PEAKS_TO_AVERAGE = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]             sample_time;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          last_of_series;
  } spae_in_t;

  typedef struct packed {
    logic [AMP_W-1:0] amplitude;
    logic             used_maximum_fallback;
  } spae_out_t;

  // one classified sample
  typedef struct packed {
    logic             has_peak;
    logic [MAG_W-1:0] peak_mag;
    logic             last;
    logic             short_series;
    logic [MAG_W-1:0] largest;
  } spae_job_t;

  function automatic logic [MAG_W-1:0] magnitude(input logic signed [SAMPLE_BITS-1:0] v);
    logic signed [MAG_W-1:0] w;
    w = MAG_W'(v);
    return (w < 0) ? MAG_W'(-w) : MAG_W'(w);
  endfunction

endpackage

/* rtl/spae_front.sv */
// Sample front end: neighbor window, peak test and running maximum.
// Emits one job per accepted sample. Depends on spae_pkg.
module spae_front import spae_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [TIME_W-1:0] transient_time,
  input  logic              in_valid,
  output logic              in_stall,
  input  spae_in_t          in_data,
  input  logic              q_full,
  output logic              push,
  output spae_job_t         job
);

  logic signed [SAMPLE_BITS-1:0] prev;
  logic signed [SAMPLE_BITS-1:0] mid;
  logic [TIME_W-1:0]             mid_time;
  logic [SEEN_W-1:0]             seen;
  logic [MAG_W-1:0]              largest;
  logic [MAG_W-1:0]              largest_next;
  logic signed [SAMPLE_BITS-1:0] x;
  logic [MAG_W-1:0]              x_mag;
  logic                          accept;

  assign x        = in_data.sample_value;
  assign x_mag    = magnitude(x);
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept;

  always_comb begin
    largest_next = largest;
    if (in_data.sample_time >= transient_time && x_mag > largest) begin
      largest_next = x_mag;
    end
  end

  always_comb begin
    job.has_peak     = (seen >= SEEN_W'(2)) && (mid_time >= transient_time) &&
                       (mid > prev) && (mid > x);
    job.peak_mag     = magnitude(mid);
    job.last         = in_data.last_of_series;
    job.short_series = (seen < SEEN_W'(2));
    job.largest      = largest_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev     <= '0;
      mid      <= '0;
      mid_time <= '0;
      seen     <= '0;
      largest  <= '0;
    end else if (accept) begin
      if (in_data.last_of_series) begin
        prev     <= '0;
        mid      <= '0;
        mid_time <= '0;
        seen     <= '0;
        largest  <= '0;
      end else begin
        prev     <= mid;
        mid      <= x;
        mid_time <= in_data.sample_time;
        seen     <= (seen == SEEN_W'(SEEN_FULL)) ? seen : seen + SEEN_W'(1);
        largest  <= largest_next;
      end
    end
  end

endmodule

/* rtl/spae_queue.sv */
// Two-entry job queue between the front end and the back end.
// Depends on spae_pkg.
module spae_queue import spae_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  spae_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      q_valid,
  output spae_job_t q_job
);

  spae_job_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/spae_back.sv */
// Back end: peak ring, end-of-series window sum and restoring divider,
// plus the output register. Depends on spae_pkg.
module spae_back import spae_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [PTA_W-1:0] peaks_to_average,
  input  logic             q_valid,
  input  spae_job_t        q_job,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output spae_out_t        out_data
);

  typedef enum logic [2:0] {
    B_TAKE = 3'b001,
    B_SUM  = 3'b010,
    B_DIV  = 3'b100
  } bstate_t;

  bstate_t           state;
  logic [MAG_W-1:0]  ring [MAX_PEAKS];
  logic [MAG_W-1:0]  rdata;
  logic [PTR_W-1:0]  ptr;
  logic [CNT_W-1:0]  found;
  logic [PTR_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  left;
  logic [CNT_W-1:0]  cnt;
  logic              pend;
  logic              rd_en;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] step;

  logic [PTR_W-1:0]  ptr_eff;
  logic [CNT_W-1:0]  found_eff;
  logic [CNT_W-1:0]  want;
  logic [CNT_W-1:0]  take_cnt;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    diff;
  logic              ge;

  assign pop   = q_valid && (state == B_TAKE) && (!q_job.last || !out_valid);
  assign rd_en = (state == B_SUM) && (left != '0);

  always_comb begin
    ptr_eff   = ptr;
    found_eff = found;
    if (q_job.has_peak) begin
      ptr_eff = ptr + PTR_W'(1);
      if (found != CNT_W'(MAX_PEAKS)) found_eff = found + CNT_W'(1);
    end
    // zero counts as one, anything past the ring depth as the depth
    priority if (peaks_to_average == '0) begin
      want = CNT_W'(1);
    end else if (CNT_W'(peaks_to_average) > CNT_W'(MAX_PEAKS)) begin
      want = CNT_W'(MAX_PEAKS);
    end else begin
      want = CNT_W'(peaks_to_average);
    end
    take_cnt = (found_eff < want) ? found_eff : want;
  end

  always_comb begin
    rem_sh = {rem, quo[SUM_W-1]};
    diff   = rem_sh - {1'b0, cnt};
    ge     = (rem_sh >= {1'b0, cnt});
  end

  // ring storage, registered read
  always_ff @(posedge clk) begin
    if (pop && q_job.has_peak) begin
      ring[ptr] <= q_job.peak_mag;
    end
    if (rd_en) begin
      rdata <= ring[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_TAKE;
      ptr       <= '0;
      found     <= '0;
      left      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        B_TAKE: begin
          if (pop) begin
            if (!q_job.last) begin
              ptr   <= ptr_eff;
              found <= found_eff;
            end else begin
              ptr   <= '0;
              found <= '0;
              priority if (q_job.short_series) begin
                out_data  <= '{amplitude: '0, used_maximum_fallback: 1'b0};
                out_valid <= 1'b1;
              end else if (found_eff == '0) begin
                out_data  <= '{amplitude: q_job.largest[AMP_W-1:0],
                               used_maximum_fallback: 1'b1};
                out_valid <= 1'b1;
              end else begin
                cnt    <= take_cnt;
                left   <= take_cnt;
                rd_idx <= ptr_eff - PTR_W'(1);
                sum    <= '0;
                pend   <= 1'b0;
                state  <= B_SUM;
              end
            end
          end
        end
        B_SUM: begin
          // walk back from the newest peak, one read a cycle
          if (rd_en) begin
            rd_idx <= rd_idx - PTR_W'(1);
            left   <= left - CNT_W'(1);
          end
          pend <= rd_en;
          if (pend) sum <= sum + SUM_W'(rdata);
          if (!rd_en && !pend) begin
            quo   <= sum;
            rem   <= '0;
            step  <= '0;
            state <= B_DIV;
          end
        end
        B_DIV: begin
          quo <= {quo[SUM_W-2:0], ge};
          rem <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
          step <= step + STEP_W'(1);
          if (step == STEP_W'(SUM_W - 1)) begin
            out_data  <= '{amplitude: {quo[AMP_W-2:0], ge},
                           used_maximum_fallback: 1'b0};
            out_valid <= 1'b1;
            state     <= B_TAKE;
          end
        end
        default: state <= B_TAKE;
      endcase
    end
  end

  a_found_bounded: assert property (@(posedge clk) disable iff (rst)
    found <= CNT_W'(MAX_PEAKS))
    else $error("peak count past ring depth");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> (cnt != '0) && (cnt <= CNT_W'(MAX_PEAKS)))
    else $error("divisor out of range");

  a_busy_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == B_SUM || state == B_DIV) |-> !out_valid)
    else $error("output register busy during mean");

  a_sum_reads: assert property (@(posedge clk) disable iff (rst)
    (state == B_SUM) |-> (left <= cnt))
    else $error("more ring reads than peaks averaged");

endmodule

/* rtl/steady_peak_amplitude_estimator.sv */
// Steady peak amplitude estimator. Samples are taken at one beat per cycle
// while the queue has room; each one is classified in the front end and
// queued (two entries) for the back end. A series ending with too few
// samples or no peak gives its result in the cycle after its last beat
// leaves the queue. A series that ends with a mean occupies the back end for
// the ring reads and summing of N peaks (N = peaks averaged, up to 16) and
// then a one-bit-per-cycle divider; samples of the next series keep coming
// in until the queue fills. The result beat is held in an output register
// until taken. Depends on spae_pkg, spae_front, spae_queue, spae_back.
module steady_peak_amplitude_estimator import spae_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_en,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  spae_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output spae_out_t        out_data
);

  logic [TIME_W-1:0] transient_time;
  logic [PTA_W-1:0]  peaks_to_average;
  logic              push;
  logic              q_full;
  logic              pop;
  logic              q_valid;
  spae_job_t         push_job;
  spae_job_t         q_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      transient_time   <= '0;
      peaks_to_average <= PTA_RESET;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_TRANSIENT_TIME:   transient_time   <= cfg_data[TIME_W-1:0];
        REG_PEAKS_TO_AVERAGE: peaks_to_average <= cfg_data[PTA_W-1:0];
        default:              transient_time   <= transient_time;
      endcase
    end
  end

  spae_front u_front (
    .clk            (clk),
    .rst            (rst),
    .transient_time (transient_time),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .q_full         (q_full),
    .push           (push),
    .job            (push_job)
  );

  spae_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  spae_back u_back (
    .clk              (clk),
    .rst              (rst),
    .peaks_to_average (peaks_to_average),
    .q_valid          (q_valid),
    .q_job            (q_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data)
  );

endmodule

/* bench/spae_amplitude_checker.sv */
`timescale 1ns / 1ps
// Checker for the steady peak amplitude estimator: tracks register writes,
// predicts the amplitude estimate of every series and compares result beats.
// Depends on spae_pkg.
module spae_amplitude_checker import spae_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_en,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  spae_in_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  spae_out_t        out_data,
  output int               fails,
  output int               pending,
  output int               checked
);

  logic [TIME_W-1:0]             transient;
  logic [PTA_W-1:0]              avg_count;

  logic signed [SAMPLE_BITS-1:0] prev_s;
  logic signed [SAMPLE_BITS-1:0] mid_s;
  logic [TIME_W-1:0]             mid_t;
  int                            seen;
  logic [MAG_W-1:0]              peak_mags [MAX_PEAKS];
  logic [PTR_W-1:0]              wr_ptr;
  int                            found;
  logic [MAG_W-1:0]              largest;

  spae_out_t                     amp_due [$];

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [SAMPLE_BITS-1:0] v);
    logic signed [MAG_W:0] wide;
    wide = v;
    if (wide < 0) wide = -wide;
    return wide[MAG_W-1:0];
  endfunction

  task automatic restart_series();
    prev_s  = '0;
    mid_s   = '0;
    mid_t   = '0;
    seen    = 0;
    wr_ptr  = '0;
    found   = 0;
    largest = '0;
  endtask

  task automatic take_sample(input spae_in_t beat);
    logic signed [SAMPLE_BITS-1:0] x;
    logic [MAG_W-1:0]              mag;
    logic [SUM_W-1:0]              total;
    logic [PTR_W-1:0]              idx;
    spae_out_t                     res;
    int                            want;
    int                            cnt;
    int                            k;
    x = beat.sample_value;
    // the middle sample is judged once its right neighbour arrives
    if (seen >= 2 && mid_t >= transient && mid_s > prev_s && mid_s > x) begin
      peak_mags[wr_ptr] = mag_of(mid_s);
      wr_ptr = wr_ptr + 1'b1;
      if (found < MAX_PEAKS) found++;
    end
    mag = mag_of(x);
    if (beat.sample_time >= transient && mag > largest) largest = mag;
    prev_s = mid_s;
    mid_s  = x;
    mid_t  = beat.sample_time;
    if (seen < 3) seen++;
    if (beat.last_of_series) begin
      if (seen < 3) begin
        res.amplitude             = '0;
        res.used_maximum_fallback = 1'b0;
      end else if (found == 0) begin
        res.amplitude             = largest[AMP_W-1:0];
        res.used_maximum_fallback = 1'b1;
      end else begin
        want = avg_count;
        if (want == 0) want = 1;
        if (want > MAX_PEAKS) want = MAX_PEAKS;
        cnt   = (found < want) ? found : want;
        total = '0;
        idx   = wr_ptr;
        for (k = 0; k < cnt; k++) begin
          idx   = idx - 1'b1;
          total = total + peak_mags[idx];
        end
        res.amplitude             = AMP_W'(total / cnt);
        res.used_maximum_fallback = 1'b0;
      end
      amp_due = {amp_due, res};
      restart_series();
    end
  endtask

  initial begin
    fails   = 0;
    pending = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    spae_out_t want_beat;
    if (rst) begin
      transient = '0;
      avg_count = PTA_RESET;
      restart_series();
      amp_due.delete();
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          REG_TRANSIENT_TIME:   transient = cfg_data[TIME_W-1:0];
          REG_PEAKS_TO_AVERAGE: avg_count = cfg_data[PTA_W-1:0];
        endcase
      end
      // results leave only after their last sample has been taken, so compare first
      if (out_valid && !out_stall) begin
        if (amp_due.size() == 0) begin
          $error("result beat with no estimate pending: amplitude %0d fallback %0b",
                 out_data.amplitude, out_data.used_maximum_fallback);
          fails++;
        end else begin
          want_beat = amp_due.pop_front();
          checked++;
          if (out_data.amplitude !== want_beat.amplitude) begin
            $error("amplitude: expected %0d, got %0d",
                   want_beat.amplitude, out_data.amplitude);
            fails++;
          end
          if (out_data.used_maximum_fallback !== want_beat.used_maximum_fallback) begin
            $error("used_maximum_fallback: expected %0b, got %0b",
                   want_beat.used_maximum_fallback, out_data.used_maximum_fallback);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) take_sample(in_data);
    end
    pending = amp_due.size();
  end

endmodule

/* bench/steady_peak_amplitude_estimator_test.sv */
`timescale 1ns / 1ps
// Top of the steady peak amplitude estimator bench: clock, reset, register
// writes and sample stimulus, plus the verdict. Depends on spae_pkg, the
// estimator RTL and spae_amplitude_checker.
module steady_peak_amplitude_estimator_test;
  import spae_pkg::*;

  localparam int TOTAL_SAMPLES = 550;
  localparam int DIRECTED      = 24;
  localparam int PHASES        = 7;
  localparam int DRAIN         = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 300000;

  typedef enum int {SHAPE_WAVE, SHAPE_NOISE, SHAPE_RAMP, SHAPE_FLAT} shape_t;

  logic             clk;
  logic             rst;
  logic             cfg_en;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  spae_in_t         in_data;
  logic             out_valid;
  logic             out_stall;
  spae_out_t        out_data;

  int fails;
  int pending;
  int checked;
  int cycles;
  int n_sent;
  int n_series;
  int n_settings;
  bit in_busy;
  logic [TIME_W-1:0] tt_now;

  steady_peak_amplitude_estimator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  spae_amplitude_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fails     (fails),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic spae_in_t beat_of(input logic [TIME_W-1:0] t, input int v, input bit last);
    spae_in_t b;
    b.sample_time    = t;
    b.sample_value   = v[SAMPLE_BITS-1:0];
    b.last_of_series = last;
    return b;
  endfunction

  task automatic send_sample(input spae_in_t beat);
    int gap;
    gap = in_busy ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    n_sent++;
    if (beat.last_of_series) n_series++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_en <= 1'b0;
    @(negedge clk);
  endtask

  // let every estimate come out, then give the back end time to go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic send_series(input int len, input shape_t shape);
    logic [TIME_W-1:0] t;
    int v, dir, run, step_max, i;
    t = $urandom_range(0, 1) ? tt_now - $urandom_range(0, 24) : $urandom();
    v = $urandom_range(0, 65535) - 32768;
    dir = $urandom_range(0, 1) ? 1 : -1;
    run = $urandom_range(1, 3);
    step_max = 1 << $urandom_range(2, 15);
    in_busy = $urandom_range(0, 3) != 0;
    for (i = 0; i < len; i++) begin
      case (shape)
        SHAPE_NOISE: v = $urandom_range(0, 65535) - 32768;
        SHAPE_RAMP:  v = v + dir * $urandom_range(0, step_max);
        SHAPE_FLAT:  ;
        default: begin
          if (run == 0) begin
            dir = -dir;
            run = $urandom_range(1, 3);
          end
          v = v + dir * $urandom_range(1, step_max);
          run--;
        end
      endcase
      if (shape == SHAPE_WAVE && $urandom_range(0, 11) == 0) v = dir > 0 ? 32767 : -32768;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      if ($urandom_range(0, 24) == 0) t = $urandom();
      else t = t + $urandom_range(0, 3);
      send_sample(beat_of(t, v, i == len - 1));
    end
  endtask

  // receiver: random stalls per beat, plus two long hold-offs to back up the queue
  initial begin
    int wait_n;
    int taken;
    bit busy;
    out_stall <= 1'b0;
    taken = 0;
    busy  = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken % 8 == 0) busy = $urandom_range(0, 2) != 0;
      wait_n = busy ? $urandom_range(0, 6) : 0;
      if (taken == 12 || taken == 30) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d estimates outstanding", cycles, pending);
    $display("steady_peak_amplitude_estimator_test: errors");
    $finish;
  end

  initial begin
    int p, r, len, phase_end;
    logic [TIME_W-1:0] tt_new;
    logic [PTA_W-1:0]  pta_new;
    shape_t shape;
    rst        = 1'b1;
    cfg_en     = 1'b0;
    cfg_index  = REG_TRANSIENT_TIME;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    n_sent     = 0;
    n_series   = 0;
    n_settings = 1;
    in_busy    = 1'b1;
    tt_now     = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: short series, full-scale peak, most negative magnitude,
    // plateau (no strict peak), negative peak, transient cut-off
    send_sample(beat_of(0, 1234, 1));
    send_sample(beat_of(0, -32768, 0));
    send_sample(beat_of(1, 32767, 1));
    send_sample(beat_of(0, -32768, 0));
    send_sample(beat_of(1, 32767, 0));
    send_sample(beat_of(2, -32768, 1));
    send_sample(beat_of(3, 0, 0));
    send_sample(beat_of(4, -5, 0));
    send_sample(beat_of(5, -32768, 1));
    send_sample(beat_of(6, 1, 0));
    send_sample(beat_of(7, 5, 0));
    send_sample(beat_of(8, 5, 0));
    send_sample(beat_of(9, 1, 1));
    send_sample(beat_of(10, -100, 0));
    send_sample(beat_of(11, -3, 0));
    send_sample(beat_of(12, -100, 1));
    settle();
    tt_now = 100;
    write_reg(REG_TRANSIENT_TIME, tt_now);
    n_settings++;
    send_sample(beat_of(97, 50, 0));
    send_sample(beat_of(98, 60, 0));
    send_sample(beat_of(99, 0, 0));
    send_sample(beat_of(100, 7, 0));
    send_sample(beat_of(101, 0, 1));
    // everything before the transient: fallback with nothing seen
    send_sample(beat_of(0, 5, 0));
    send_sample(beat_of(1, 9, 0));
    send_sample(beat_of(2, 1, 1));
    settle();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin tt_new = '0;         pta_new = 5'd1;  end
        1:       begin tt_new = $urandom(); pta_new = 5'd16; end
        2:       begin tt_new = '0;         pta_new = 5'd0;  end
        3:       begin tt_new = $urandom(); pta_new = 5'd31; end
        4:       begin tt_new = '1;         pta_new = 5'd5;  end
        5:       begin tt_new = $urandom(); pta_new = 5'd17; end
        default: begin tt_new = '0;         pta_new = PTA_W'($urandom_range(2, 15)); end
      endcase
      tt_now = tt_new;
      write_reg(REG_TRANSIENT_TIME, tt_new);
      write_reg(REG_PEAKS_TO_AVERAGE, CFG_W'(pta_new));
      n_settings++;
      phase_end = DIRECTED + (p + 1) * (TOTAL_SAMPLES - DIRECTED) / PHASES;
      while (n_sent < phase_end) begin
        r   = $urandom_range(0, 9);
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 70) : $urandom_range(3, 24);
        case (r)
          0:       begin shape = SHAPE_NOISE; len = $urandom_range(1, 2); end
          1:       shape = SHAPE_RAMP;
          2:       shape = SHAPE_FLAT;
          3:       shape = SHAPE_NOISE;
          default: shape = SHAPE_WAVE;
        endcase
        send_series(len, shape);
      end
      settle();
    end

    $display("covered %0d samples in %0d series under %0d register settings",
             n_sent, n_series, n_settings);
    $display("%0d estimates compared, %0d mismatches", checked, fails);
    if (fails == 0 && pending == 0) begin
      $display("steady_peak_amplitude_estimator_test: clean");
    end else begin
      $display("steady_peak_amplitude_estimator_test: errors");
    end
    $finish;
  end

endmodule
